>>> hw/rtl/i2cm_pkg.sv
// shared types and constants for the i2c master register front end
package i2cm_pkg;

	// register byte offsets
	localparam logic [11:0] OFF_CONTROL = 12'h000;
	localparam logic [11:0] OFF_STATUS  = 12'h004;
	localparam logic [11:0] OFF_OWN_ADR = 12'h008;
	localparam logic [11:0] OFF_DATA    = 12'h00c;
	localparam logic [11:0] OFF_LINE    = 12'h010;
	localparam logic [11:0] OFF_AUX0    = 12'h014;
	localparam logic [11:0] OFF_AUX1    = 12'h018;
	localparam logic [11:0] OFF_AUX2    = 12'h01c;
	localparam logic [11:0] OFF_DONE    = 12'h020;

	// control register bits
	localparam int CON_ACK_GEN  = 7;
	localparam int CON_IRQ_EN   = 5;
	localparam int CON_IRQ_PEND = 4;

	// status register bits
	localparam int ST_START  = 5;
	localparam int ST_OUT_EN = 4;
	localparam int ST_LAST   = 0;

	// completion flag view bits at the done register
	localparam int OP_XFER_BIT = 8;
	localparam int OP_COND_BIT = 13;

	// internal completion flag positions
	localparam int DONE_XFER = 0;
	localparam int DONE_COND = 1;

	// status mode field
	localparam logic [1:0] MODE_MRX = 2'd2;

	localparam logic [31:0] DATA_RESET = 32'h0000_00ff;

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_START = 2'd1,
		ACT_SEND  = 2'd2,
		ACT_RECV  = 2'd3
	} bus_act_t;

	typedef enum logic {
		REQ_READ  = 1'b0,
		REQ_WRITE = 1'b1
	} req_t;

	typedef struct packed {
		logic        req_type;
		logic [11:0] reg_offset;
		logic [31:0] write_data;
		logic        target_nack;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_level;
		logic        bus_stop;
		bus_act_t    bus_action;
		logic [6:0]  bus_target;
		logic        bus_is_read;
		logic [7:0]  bus_tx_byte;
		logic        bus_rx_nack;
	} result_t;

endpackage

>>> hw/rtl/i2cm_core.sv
// register file and access logic of the i2c master front end
module i2cm_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  i2cm_pkg::item_t  item,
	output i2cm_pkg::result_t res
);

	logic [31:0] control_q, status_q, own_adr_q, data_q, line_q;
	logic [31:0] aux0_q, aux1_q, aux2_q;
	logic [1:0]  done_q;
	logic        active_q, ready_q;

	logic [31:0] control_n, status_n, own_adr_n, data_n, line_n;
	logic [31:0] aux0_n, aux1_n, aux2_n;
	logic [1:0]  done_n;
	logic        active_n, ready_n;

	logic [31:0] v;
	logic [1:0]  om, nm;
	logic        changed;

	always_comb begin
		v         = item.write_data;
		om        = status_q[7:6];
		nm        = v[7:6];
		changed   = status_q[i2cm_pkg::ST_START] &&
			(!v[i2cm_pkg::ST_START] || (nm != om));
		control_n = control_q;
		status_n  = status_q;
		own_adr_n = own_adr_q;
		data_n    = data_q;
		line_n    = line_q;
		aux0_n    = aux0_q;
		aux1_n    = aux1_q;
		aux2_n    = aux2_q;
		done_n    = done_q;
		active_n  = active_q;
		ready_n   = ready_q;
		res       = '0;
		res.bus_action = i2cm_pkg::ACT_NONE;

		if (item.req_type == i2cm_pkg::REQ_READ) begin
			case (item.reg_offset)
				i2cm_pkg::OFF_CONTROL: res.read_data = control_q;
				i2cm_pkg::OFF_STATUS:  res.read_data = status_q;
				i2cm_pkg::OFF_OWN_ADR: res.read_data = own_adr_q;
				i2cm_pkg::OFF_DATA:    res.read_data = data_q;
				i2cm_pkg::OFF_LINE:    res.read_data = line_q;
				i2cm_pkg::OFF_AUX0:    res.read_data = aux0_q;
				i2cm_pkg::OFF_AUX1:    res.read_data = aux1_q;
				i2cm_pkg::OFF_AUX2:    res.read_data = aux2_q;
				i2cm_pkg::OFF_DONE: begin
					res.read_data[i2cm_pkg::OP_XFER_BIT] = done_q[i2cm_pkg::DONE_XFER];
					res.read_data[i2cm_pkg::OP_COND_BIT] = done_q[i2cm_pkg::DONE_COND];
				end
				default: res.read_data = '0;
			endcase
		end else begin
			case (item.reg_offset)
				i2cm_pkg::OFF_CONTROL: begin
					control_n = v;
					control_n[i2cm_pkg::CON_IRQ_PEND] = 1'b0;
					if (v[i2cm_pkg::CON_IRQ_PEND] && active_q) begin
						status_n[i2cm_pkg::ST_LAST] = 1'b0;
						if (om == i2cm_pkg::MODE_MRX) begin
							data_n = {24'd0, item.rx_byte};
							res.bus_action = i2cm_pkg::ACT_RECV;
							res.bus_rx_nack = !v[i2cm_pkg::CON_ACK_GEN];
							done_n[i2cm_pkg::DONE_XFER] = 1'b1;
							control_n[i2cm_pkg::CON_IRQ_PEND] = 1'b1;
						end else if (ready_q) begin
							res.bus_action = i2cm_pkg::ACT_SEND;
							res.bus_tx_byte = data_q[7:0];
							if (item.target_nack) begin
								status_n[i2cm_pkg::ST_LAST] = 1'b1;
							end
							ready_n = 1'b0;
							done_n[i2cm_pkg::DONE_XFER] = 1'b1;
							control_n[i2cm_pkg::CON_IRQ_PEND] = 1'b1;
						end
					end
				end
				i2cm_pkg::OFF_STATUS: begin
					if (active_q && changed) begin
						res.bus_stop = 1'b1;
						active_n = 1'b0;
						ready_n  = 1'b0;
					end
					status_n = v;
					status_n[i2cm_pkg::ST_LAST] = 1'b0;
					if (changed) begin
						done_n[i2cm_pkg::DONE_COND] = 1'b1;
						control_n[i2cm_pkg::CON_IRQ_PEND] = 1'b1;
					end
					// master modes have the upper mode bit set
					if (v[i2cm_pkg::ST_START] && v[i2cm_pkg::ST_OUT_EN] && nm[1] &&
						!active_n) begin
						res.bus_action  = i2cm_pkg::ACT_START;
						res.bus_target  = data_q[7:1];
						res.bus_is_read = (nm == i2cm_pkg::MODE_MRX);
						if (item.target_nack) begin
							status_n[i2cm_pkg::ST_LAST] = 1'b1;
						end else begin
							active_n = 1'b1;
						end
						ready_n = 1'b0;
						done_n[i2cm_pkg::DONE_XFER] = 1'b1;
						control_n[i2cm_pkg::CON_IRQ_PEND] = 1'b1;
					end
				end
				i2cm_pkg::OFF_OWN_ADR: begin
					if (!status_q[i2cm_pkg::ST_OUT_EN]) begin
						own_adr_n = v;
					end
				end
				i2cm_pkg::OFF_DATA: begin
					data_n  = v;
					ready_n = 1'b1;
				end
				i2cm_pkg::OFF_LINE: line_n = v;
				i2cm_pkg::OFF_AUX0: aux0_n = v;
				i2cm_pkg::OFF_AUX1: aux1_n = v;
				i2cm_pkg::OFF_AUX2: aux2_n = v;
				i2cm_pkg::OFF_DONE: begin
					if (v[i2cm_pkg::OP_XFER_BIT]) done_n[i2cm_pkg::DONE_XFER] = 1'b0;
					if (v[i2cm_pkg::OP_COND_BIT]) done_n[i2cm_pkg::DONE_COND] = 1'b0;
				end
				default: ;
			endcase
		end

		res.irq_level = (control_n[i2cm_pkg::CON_IRQ_EN] && control_n[i2cm_pkg::CON_IRQ_PEND]) ||
			(aux0_n[0] && (done_n != 2'b00));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q <= '0;
			status_q  <= '0;
			own_adr_q <= '0;
			data_q    <= i2cm_pkg::DATA_RESET;
			line_q    <= '0;
			aux0_q    <= '0;
			aux1_q    <= '0;
			aux2_q    <= '0;
			done_q    <= '0;
			active_q  <= 1'b0;
			ready_q   <= 1'b0;
		end else if (fire) begin
			control_q <= control_n;
			status_q  <= status_n;
			own_adr_q <= own_adr_n;
			data_q    <= data_n;
			line_q    <= line_n;
			aux0_q    <= aux0_n;
			aux1_q    <= aux1_n;
			aux2_q    <= aux2_n;
			done_q    <= done_n;
			active_q  <= active_n;
			ready_q   <= ready_n;
		end
	end

	// a start never overlaps a transfer that was not stopped
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.bus_action == i2cm_pkg::ACT_START |-> !active_q || res.bus_stop)
		else $error("start issued over an active transfer");

	// the rx nack only goes with a receive
	a_rxn_recv: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.bus_rx_nack |-> res.bus_action == i2cm_pkg::ACT_RECV)
		else $error("rx nack without receive");

	// a sent byte consumes the ready flag
	a_send_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.bus_action == i2cm_pkg::ACT_SEND |=> !ready_q)
		else $error("tx ready still set after send");

	// writes return zero data
	a_wr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.req_type == i2cm_pkg::REQ_WRITE |-> res.read_data == '0)
		else $error("write returned read data");

	// any bus action marks the transfer flag for the next access
	a_act_done: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.bus_action != i2cm_pkg::ACT_NONE |=> done_q[i2cm_pkg::DONE_XFER])
		else $error("bus action without transfer done flag");

endmodule

>>> hw/rtl/i2c_master_register_controller_unit.sv
// top level of the i2c master register front end with input and result registers
//
// Register front end of an i2c master. Each item is one 32-bit register
// access (read or write) and carries the target's reply (nack, received byte)
// for any bus action that access starts. One item is accepted per clock while
// in_ready is high; the item waits in the input register, and when it
// advances the register file update and decode land in the result register.
// Throughput stays at one item per cycle as long as the result side takes an
// item each cycle; a stalled result register holds its item and the input
// register can still take one more before in_ready drops. Register map:
// 0x00 control (bit7 ack generate, bit5 irq enable, bit4 irq pending), 0x04
// status (bits7:6 mode, bit5 start, bit4 output enable, bit0 last nack), 0x08
// own address, 0x0c data, 0x10 line control, 0x14..0x1c auxiliary words
// (0x14 bit0 enables the completion interrupt), 0x20 completion flags (bit8
// transfer, bit13 condition, write one to clear). Unmapped offsets read zero
// and ignore writes; writes return zero read data.
module i2c_master_register_controller_unit (
	input  logic        clk,
	input  logic        arst_n,
	// item input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [11:0] reg_offset,
	input  logic [31:0] write_data,
	input  logic        target_nack,
	input  logic [7:0]  rx_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_data,
	output logic        irq_level,
	output logic        bus_stop,
	output logic [1:0]  bus_action,
	output logic [6:0]  bus_target,
	output logic        bus_is_read,
	output logic [7:0]  bus_tx_byte,
	output logic        bus_rx_nack
);

	// input register stage
	logic              valid_s1;
	i2cm_pkg::item_t   item_s1;

	// result register
	logic              out_valid_q;
	i2cm_pkg::result_t res_q;
	i2cm_pkg::result_t res_c;

	// the input stage retires into the result register when that is free or draining
	logic advance;
	logic take;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take || (valid_s1 && !advance);
		end
	end

	// payload holds no reset
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.req_type    <= req_type;
			item_s1.reg_offset  <= reg_offset;
			item_s1.write_data  <= write_data;
			item_s1.target_nack <= target_nack;
			item_s1.rx_byte     <= rx_byte;
		end
	end

	// register file and decode, state commits when the item retires
	i2cm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.res    (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= advance || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_c;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = res_q.read_data;
	assign irq_level   = res_q.irq_level;
	assign bus_stop    = res_q.bus_stop;
	assign bus_action  = res_q.bus_action;
	assign bus_target  = res_q.bus_target;
	assign bus_is_read = res_q.bus_is_read;
	assign bus_tx_byte = res_q.bus_tx_byte;
	assign bus_rx_nack = res_q.bus_rx_nack;

endmodule

>>> test/tb_i2c_master_register_controller_unit.sv
// testbench for the i2c master register front end: directed and random register traffic
`timescale 1ns / 1ps

module tb_i2c_master_register_controller_unit;
	import i2cm_pkg::*;

	// master transmit mode, the package only names the receive mode
	localparam logic [1:0] MODE_MTX = 2'd3;
	localparam int RANDOM_ITEMS = 1000;
	localparam int CYCLE_LIMIT = 400000;
	// result passes the input and result registers after acceptance, wait a little longer at the end
	localparam int TAIL_CYCLES = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        req_type = 1'b0;
	logic [11:0] reg_offset = '0;
	logic [31:0] write_data = '0;
	logic        target_nack = 1'b0;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] read_data;
	logic        irq_level;
	logic        bus_stop;
	logic [1:0]  bus_action;
	logic [6:0]  bus_target;
	logic        bus_is_read;
	logic [7:0]  bus_tx_byte;
	logic        bus_rx_nack;

	i2c_master_register_controller_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.reg_offset (reg_offset),
		.write_data (write_data),
		.target_nack(target_nack),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_data  (read_data),
		.irq_level  (irq_level),
		.bus_stop   (bus_stop),
		.bus_action (bus_action),
		.bus_target (bus_target),
		.bus_is_read(bus_is_read),
		.bus_tx_byte(bus_tx_byte),
		.bus_rx_nack(bus_rx_nack)
	);

	always #1 clk = ~clk;

	// shadow copy of the register file, updated as each item is accepted
	logic [31:0] shadow_control;
	logic [31:0] shadow_status;
	logic [31:0] shadow_own_adr;
	logic [31:0] shadow_data;
	logic [31:0] shadow_line;
	logic [31:0] shadow_aux [3];
	logic [1:0]  shadow_done;
	logic        shadow_active;
	logic        shadow_tx_ready;

	// predicted results of accepted accesses, oldest first
	result_t pending_replies [$];
	result_t oldest_reply;

	int error_count = 0;
	int sent_count = 0;
	int cycle_count = 0;
	int out_stall = 0;
	// when set, neither side idles between items
	bit no_idle = 1'b0;

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	function automatic logic [31:0] status_word(input logic [1:0] mode, input logic start,
		input logic oen);
		logic [31:0] w;
		w = '0;
		w[7:6] = mode;
		w[ST_START] = start;
		w[ST_OUT_EN] = oen;
		return w;
	endfunction

	function automatic logic [31:0] control_word(input logic ack_gen, input logic irq_en,
		input logic pend);
		logic [31:0] w;
		w = '0;
		w[CON_ACK_GEN] = ack_gen;
		w[CON_IRQ_EN] = irq_en;
		w[CON_IRQ_PEND] = pend;
		return w;
	endfunction

	// a completion raises its flag and the pending bit of the control register
	task automatic set_done(input int flag);
		shadow_done[flag] = 1'b1;
		shadow_control[CON_IRQ_PEND] = 1'b1;
	endtask

	task automatic predict_access(input req_t kind, input logic [11:0] off,
		input logic [31:0] wdata, input logic nack, input logic [7:0] rxb, output result_t r);
		logic [1:0] prev_mode;
		logic [1:0] new_mode;
		logic       changed;
		logic       start;
		r = '0;
		r.bus_action = ACT_NONE;
		if (kind == REQ_READ) begin
			case (off)
				OFF_CONTROL: r.read_data = shadow_control;
				OFF_STATUS:  r.read_data = shadow_status;
				OFF_OWN_ADR: r.read_data = shadow_own_adr;
				OFF_DATA:    r.read_data = shadow_data;
				OFF_LINE:    r.read_data = shadow_line;
				OFF_AUX0:    r.read_data = shadow_aux[0];
				OFF_AUX1:    r.read_data = shadow_aux[1];
				OFF_AUX2:    r.read_data = shadow_aux[2];
				OFF_DONE: begin
					r.read_data[OP_XFER_BIT] = shadow_done[DONE_XFER];
					r.read_data[OP_COND_BIT] = shadow_done[DONE_COND];
				end
				default: r.read_data = '0;
			endcase
		end else begin
			case (off)
				OFF_CONTROL: begin
					shadow_control = wdata;
					shadow_control[CON_IRQ_PEND] = 1'b0;
					// acknowledge of an active transfer moves the next byte
					if (wdata[CON_IRQ_PEND] && shadow_active) begin
						shadow_status[ST_LAST] = 1'b0;
						if (shadow_status[7:6] == MODE_MRX) begin
							shadow_data = {24'h0, rxb};
							r.bus_action = ACT_RECV;
							r.bus_rx_nack = !shadow_control[CON_ACK_GEN];
							set_done(DONE_XFER);
						end else if (shadow_tx_ready) begin
							r.bus_action = ACT_SEND;
							r.bus_tx_byte = shadow_data[7:0];
							if (nack)
								shadow_status[ST_LAST] = 1'b1;
							shadow_tx_ready = 1'b0;
							set_done(DONE_XFER);
						end
					end
				end
				OFF_STATUS: begin
					prev_mode = shadow_status[7:6];
					new_mode = wdata[7:6];
					start = wdata[ST_START];
					changed = shadow_status[ST_START] && (!start || new_mode != prev_mode);
					if (shadow_active && changed) begin
						r.bus_stop = 1'b1;
						shadow_active = 1'b0;
						shadow_tx_ready = 1'b0;
					end
					shadow_status = wdata;
					shadow_status[ST_LAST] = 1'b0;
					if (changed)
						set_done(DONE_COND);
					if (start && wdata[ST_OUT_EN] && (new_mode == MODE_MRX || new_mode == MODE_MTX)
						&& !shadow_active) begin
						r.bus_action = ACT_START;
						r.bus_target = shadow_data[7:1];
						r.bus_is_read = (new_mode == MODE_MRX);
						if (nack)
							shadow_status[ST_LAST] = 1'b1;
						else
							shadow_active = 1'b1;
						shadow_tx_ready = 1'b0;
						set_done(DONE_XFER);
					end
				end
				OFF_OWN_ADR: if (!shadow_status[ST_OUT_EN]) shadow_own_adr = wdata;
				OFF_DATA: begin
					shadow_data = wdata;
					shadow_tx_ready = 1'b1;
				end
				OFF_LINE: shadow_line = wdata;
				OFF_AUX0: shadow_aux[0] = wdata;
				OFF_AUX1: shadow_aux[1] = wdata;
				OFF_AUX2: shadow_aux[2] = wdata;
				OFF_DONE: begin
					if (wdata[OP_XFER_BIT])
						shadow_done[DONE_XFER] = 1'b0;
					if (wdata[OP_COND_BIT])
						shadow_done[DONE_COND] = 1'b0;
				end
				default: ;
			endcase
		end
		r.irq_level = (shadow_control[CON_IRQ_EN] && shadow_control[CON_IRQ_PEND])
			|| (shadow_aux[0][0] && (|shadow_done));
	endtask

	// present one item after a random gap, hold it until accepted, then predict it
	// entered and left at a falling edge
	task automatic send_item(input req_t kind, input logic [11:0] off, input logic [31:0] wdata,
		input logic nack, input logic [7:0] rxb);
		int gap;
		result_t r;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		req_type = kind;
		reg_offset = off;
		write_data = wdata;
		target_nack = nack;
		rx_byte = rxb;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_access(kind, off, wdata, nack, rxb, r);
		pending_replies.push_back(r);
		sent_count++;
		@(negedge clk);
	endtask

	// sender holds off until every outstanding result is back
	task automatic wait_for_replies();
		in_valid = 1'b0;
		while (pending_replies.size() != 0)
			@(negedge clk);
	endtask

	// result side: stall a random number of cycles before taking each item
	always @(negedge clk) begin
		if (out_stall > 0) begin
			out_ready = 1'b0;
			out_stall--;
		end else begin
			out_ready = 1'b1;
		end
	end

	// compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_replies.size() == 0) begin
				report_mismatch("result with no access outstanding");
			end else begin
				oldest_reply = pending_replies.pop_front();
				check_field("read_data", read_data, oldest_reply.read_data);
				check_field("irq_level", 32'(irq_level), 32'(oldest_reply.irq_level));
				check_field("bus_stop", 32'(bus_stop), 32'(oldest_reply.bus_stop));
				check_field("bus_action", 32'(bus_action), 32'(oldest_reply.bus_action));
				check_field("bus_target", 32'(bus_target), 32'(oldest_reply.bus_target));
				check_field("bus_is_read", 32'(bus_is_read), 32'(oldest_reply.bus_is_read));
				check_field("bus_tx_byte", 32'(bus_tx_byte), 32'(oldest_reply.bus_tx_byte));
				check_field("bus_rx_nack", 32'(bus_rx_nack), 32'(oldest_reply.bus_rx_nack));
			end
			out_stall = no_idle ? 0 : $urandom_range(0, 9);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic reset_shadow();
		shadow_control = '0;
		shadow_status = '0;
		shadow_own_adr = '0;
		shadow_data = DATA_RESET;
		shadow_line = '0;
		shadow_aux[0] = '0;
		shadow_aux[1] = '0;
		shadow_aux[2] = '0;
		shadow_done = '0;
		shadow_active = 1'b0;
		shadow_tx_ready = 1'b0;
	endtask

	// values after reset, an unmapped offset with every bit set
	task automatic test_reset_state();
		send_item(REQ_READ, OFF_CONTROL, 32'h0, 1'b0, 8'h00);
		send_item(REQ_READ, OFF_STATUS, 32'hffff_ffff, 1'b1, 8'hff);
		send_item(REQ_READ, OFF_DATA, 32'h0, 1'b0, 8'h00);
		send_item(REQ_READ, OFF_DONE, 32'h0, 1'b0, 8'h00);
		send_item(REQ_READ, 12'hfff, 32'h0, 1'b0, 8'h00);
	endtask

	// one full transmit, a restart into receive, stop, flag clear and the odd cases
	task automatic test_directed_bus();
		// completion interrupt enable, then ack generate and irq enable
		send_item(REQ_WRITE, OFF_AUX0, 32'h1, 1'b0, 8'h00);
		send_item(REQ_WRITE, OFF_CONTROL, control_word(1'b1, 1'b1, 1'b0), 1'b0, 8'h00);
		// target address from data bits 7:1
		send_item(REQ_WRITE, OFF_DATA, 32'hffff_ffa5, 1'b0, 8'h00);
		send_item(REQ_WRITE, OFF_STATUS, status_word(MODE_MTX, 1'b1, 1'b1), 1'b0, 8'h00);
		send_item(REQ_WRITE, OFF_DATA, 32'h0000_003c, 1'b0, 8'h00);
		// send with a nack from the target
		send_item(REQ_WRITE, OFF_CONTROL, control_word(1'b1, 1'b1, 1'b1), 1'b1, 8'h00);
		send_item(REQ_READ, OFF_STATUS, 32'h0, 1'b0, 8'h00);
		// acknowledge with no byte ready: nothing on the bus
		send_item(REQ_WRITE, OFF_CONTROL, control_word(1'b1, 1'b1, 1'b1), 1'b0, 8'h00);
		// mode change while started: stop and restart as receive in one access
		send_item(REQ_WRITE, OFF_STATUS, status_word(MODE_MRX, 1'b1, 1'b1), 1'b0, 8'h00);
		// receive with ack generation off, then on
		send_item(REQ_WRITE, OFF_CONTROL, control_word(1'b0, 1'b1, 1'b1), 1'b0, 8'h00);
		send_item(REQ_WRITE, OFF_CONTROL, control_word(1'b1, 1'b0, 1'b1), 1'b0, 8'hff);
		send_item(REQ_READ, OFF_DATA, 32'h0, 1'b0, 8'h00);
		// own address is locked while output enable is set
		send_item(REQ_WRITE, OFF_OWN_ADR, 32'hffff_ffff, 1'b0, 8'h00);
		send_item(REQ_READ, OFF_OWN_ADR, 32'h0, 1'b0, 8'h00);
		// stop
		send_item(REQ_WRITE, OFF_STATUS, 32'h0, 1'b0, 8'h00);
		send_item(REQ_READ, OFF_DONE, 32'h0, 1'b0, 8'h00);
		send_item(REQ_WRITE, OFF_DONE, 32'hffff_ffff, 1'b0, 8'h00);
		// acknowledge with no transfer active
		send_item(REQ_WRITE, OFF_CONTROL, control_word(1'b0, 1'b1, 1'b1), 1'b1, 8'h5a);
		// start refused by the target
		send_item(REQ_WRITE, OFF_STATUS, status_word(MODE_MTX, 1'b1, 1'b1), 1'b1, 8'h00);
		send_item(REQ_WRITE, OFF_LINE, 32'hffff_ffff, 1'b0, 8'h00);
		// unaligned write is dropped
		send_item(REQ_WRITE, 12'h00d, 32'hffff_ffff, 1'b0, 8'h00);
		send_item(REQ_READ, OFF_LINE, 32'h0, 1'b0, 8'h00);
		send_item(REQ_WRITE, OFF_STATUS, 32'h0, 1'b0, 8'h00);
	endtask

	// data load, start, a few acknowledges and reads, then stop, restart or leave open
	task automatic send_session();
		logic [1:0]  mode;
		logic [31:0] w;
		int          ops;
		send_item(REQ_WRITE, OFF_DATA, $urandom, 1'($urandom_range(0, 1)), 8'($urandom));
		mode = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) :
			{1'b1, 1'($urandom_range(0, 1))};
		w = ($urandom & 32'hffff_ff0f)
			| status_word(mode, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
		send_item(REQ_WRITE, OFF_STATUS, w, $urandom_range(0, 4) == 0, 8'($urandom));
		ops = $urandom_range(1, 6);
		repeat (ops) begin
			case ($urandom_range(0, 3))
				0: send_item(REQ_WRITE, OFF_DATA, $urandom, 1'($urandom_range(0, 1)),
					8'($urandom));
				1: begin
					w = $urandom;
					if ($urandom_range(0, 4) != 0)
						w[CON_IRQ_PEND] = 1'b1;
					send_item(REQ_WRITE, OFF_CONTROL, w, $urandom_range(0, 3) == 0,
						8'($urandom));
				end
				2: send_item(REQ_READ, 12'($urandom_range(0, 8) * 4), $urandom,
					1'($urandom_range(0, 1)), 8'($urandom));
				default: send_item(REQ_WRITE, OFF_DONE, $urandom, 1'($urandom_range(0, 1)),
					8'($urandom));
			endcase
		end
		case ($urandom_range(0, 2))
			0: begin
				w = $urandom;
				w[ST_START] = 1'b0;
				send_item(REQ_WRITE, OFF_STATUS, w, 1'($urandom_range(0, 1)), 8'($urandom));
			end
			1: send_item(REQ_WRITE, OFF_STATUS, status_word(~mode, 1'b1, 1'b1),
				$urandom_range(0, 4) == 0, 8'($urandom));
			default: ;
		endcase
	endtask

	// mostly bus sessions, with plain register traffic and fully random noise
	task automatic test_random_traffic();
		int base;
		int pick;
		int next_drain;
		base = sent_count;
		next_drain = 150;
		while (sent_count - base < RANDOM_ITEMS) begin
			// one stretch with no idling on either side
			no_idle = (sent_count - base >= 400) && (sent_count - base < 500);
			if (sent_count - base >= next_drain) begin
				wait_for_replies();
				next_drain += 250;
			end
			pick = $urandom_range(0, 99);
			if (pick < 10)
				send_item(req_t'($urandom_range(0, 1)), 12'($urandom), $urandom,
					1'($urandom_range(0, 1)), 8'($urandom));
			else if (pick < 20)
				send_item(REQ_READ, 12'($urandom_range(0, 8) * 4), $urandom,
					1'($urandom_range(0, 1)), 8'($urandom));
			else if (pick < 32)
				send_item(REQ_WRITE, 12'($urandom_range(0, 8) * 4), $urandom,
					1'($urandom_range(0, 1)), 8'($urandom));
			else
				send_session();
		end
		no_idle = 1'b0;
	endtask

	initial begin
		reset_shadow();
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_state();
		test_directed_bus();
		test_random_traffic();

		// drain, then give any stray result time to show up
		wait_for_replies();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> i2c_master_register_controller_unit.f
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_core.sv
hw/rtl/i2c_master_register_controller_unit.sv
test/tb_i2c_master_register_controller_unit.sv
